>>> src/mqwl_pkg.sv
`timescale 1ns / 1ps
// mqwl_pkg: shared types and constants of the multi-queue wait list manager
// depends on nothing; used by the top level by scoped names

package mqwl_pkg;

  // default sizes of the thread and queue stores
  localparam int THREADS_DEF = 32;
  localparam int QUEUES_DEF  = 16;

  // wake all hands out at most this many words per input word
  localparam int MAX_RESULTS = 32;

  // fixed widths of the stream fields
  localparam int OP_W        = 2;
  localparam int QID_W       = 4;
  localparam int TID_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SLEEP    = 2'd0,
    OP_WAKE_ONE = 2'd1,
    OP_WAKE_ALL = 2'd2,
    OP_REMOVE   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_INTERRUPTED = 2'd1,
    ST_NOTHING     = 2'd2,
    ST_REFUSED     = 2'd3
  } status_e;

endpackage

>>> src/mqwl_ram.sv
`timescale 1ns / 1ps
// mqwl_ram: generic single write port, single read port ram with registered read
// depends on nothing

module mqwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/multi_queue_wait_list_manager.sv
`timescale 1ns / 1ps
// multi_queue_wait_list_manager: fifo wait lists over shared next-pointer ram
// depends on mqwl_pkg and mqwl_ram

// The block keeps QUEUES fifo wait lists over THREADS thread slots. Each word
// on the input stream is one operation: sleep appends a thread to a queue,
// wake one pops the head, wake all pops the queue in order (at most 32 words
// out, the final one with tlast), remove unlinks a thread from anywhere in its
// queue. One operation is in flight at a time and s_axis_tready_o is low while
// it runs. All pointers live in rams with one write port, one read port and
// registered read, and the sequencer waits for the read data on each list hop.
// An output register lets a finished word wait for m_axis_tready_i while the
// next input word is taken. Queue-empty and thread-waiting flags are
// flip-flops cleared at reset, so no clearing pass runs.

module multi_queue_wait_list_manager #(
  parameter int THREADS = mqwl_pkg::THREADS_DEF,
  parameter int QUEUES  = mqwl_pkg::QUEUES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [1:0] operation, [5:2] queue_id, [10:6] thread_id, [11] signal_pending
  input  logic [mqwl_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [4:0] woken_thread, [5] woken_valid, [7:6] status
  output logic [mqwl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  localparam int TIDW = $clog2(THREADS);
  localparam int QIDW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int CNTW = $clog2(mqwl_pkg::MAX_RESULTS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SLP_LINK,
    S_WK_HEAD,
    S_WK_WAIT,
    S_WK_EMIT,
    S_RM_QUEUE,
    S_RM_ADDR,
    S_RM_HT,
    S_RM_WAIT,
    S_RM_WALK
  } state_e;

  // input word fields
  logic [mqwl_pkg::OP_W-1:0]  in_op;
  logic [mqwl_pkg::QID_W-1:0] in_queue;
  logic [mqwl_pkg::TID_W-1:0] in_thread;
  logic                       in_sig;

  assign in_op     = s_axis_tdata_i[1:0];
  assign in_queue  = s_axis_tdata_i[5:2];
  assign in_thread = s_axis_tdata_i[10:6];
  assign in_sig    = s_axis_tdata_i[11];

  // sequencer and datapath registers
  state_e               state_q, state_d;
  mqwl_pkg::op_e        op_q, op_d;
  logic [QIDW-1:0]      q_q, q_d;
  logic [TIDW-1:0]      t_q, t_d;
  logic                 sig_q, sig_d;
  logic                 qok_q, qok_d;
  logic                 tok_q, tok_d;
  logic [TIDW-1:0]      cur_q, cur_d;
  logic [TIDW-1:0]      prev_q, prev_d;
  logic                 prev_v_q, prev_v_d;
  logic [TIDW-1:0]      tl_q, tl_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic [QUEUES-1:0]    nonempty_q, nonempty_d;
  logic [THREADS-1:0]   waiting_q, waiting_d;

  // output register
  logic                       out_v_q, out_v_d;
  logic [mqwl_pkg::TID_W-1:0] out_thr_q, out_thr_d;
  logic                       out_wv_q, out_wv_d;
  mqwl_pkg::status_e          out_st_q, out_st_d;
  logic                       out_last_q, out_last_d;

  // ram ports
  logic            head_we, tail_we, next_we, wq_we;
  logic [TIDW-1:0] head_wdata, tail_wdata, next_waddr, next_wdata;
  logic [TIDW-1:0] head_rdata, tail_rdata, next_rdata;
  logic [QIDW-1:0] wq_rdata;

  // word to emit this cycle
  logic                       emit;
  logic [mqwl_pkg::TID_W-1:0] e_thr;
  logic                       e_wv;
  mqwl_pkg::status_e          e_st;
  logic                       e_last;

  logic out_free;
  logic [TIDW-1:0] cmp_b;
  logic hit;
  logic t_is_tail;

  assign out_free = !out_v_q || m_axis_tready_i;

  // shared pointer compare: list end during wakes, target thread during walk
  assign cmp_b     = (state_q == S_RM_WALK) ? t_q : tl_q;
  assign hit       = (cur_q == cmp_b);
  assign t_is_tail = (t_q == tl_q);

  mqwl_ram #(.WIDTH(TIDW), .DEPTH(QUEUES)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (q_q),
    .wdata_i (head_wdata),
    .raddr_i (q_q),
    .rdata_o (head_rdata)
  );

  mqwl_ram #(.WIDTH(TIDW), .DEPTH(QUEUES)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (q_q),
    .wdata_i (tail_wdata),
    .raddr_i (q_q),
    .rdata_o (tail_rdata)
  );

  mqwl_ram #(.WIDTH(TIDW), .DEPTH(THREADS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (cur_q),
    .rdata_o (next_rdata)
  );

  mqwl_ram #(.WIDTH(QIDW), .DEPTH(THREADS)) u_waitq_ram (
    .clk_i   (clk_i),
    .we_i    (wq_we),
    .waddr_i (t_q),
    .wdata_i (q_q),
    .raddr_i (t_q),
    .rdata_o (wq_rdata)
  );

  // sequencer next state, ram writes and result words
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    q_d        = q_q;
    t_d        = t_q;
    sig_d      = sig_q;
    qok_d      = qok_q;
    tok_d      = tok_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    prev_v_d   = prev_v_q;
    tl_d       = tl_q;
    cnt_d      = cnt_q;
    nonempty_d = nonempty_q;
    waiting_d  = waiting_q;

    head_we    = 1'b0;
    tail_we    = 1'b0;
    next_we    = 1'b0;
    wq_we      = 1'b0;
    head_wdata = t_q;
    tail_wdata = t_q;
    next_waddr = prev_q;
    next_wdata = next_rdata;

    emit   = 1'b0;
    e_thr  = '0;
    e_wv   = 1'b0;
    e_st   = mqwl_pkg::ST_DONE;
    e_last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = mqwl_pkg::op_e'(in_op);
          q_d     = QIDW'(in_queue);
          t_d     = TIDW'(in_thread);
          sig_d   = in_sig;
          qok_d   = int'(in_queue) < QUEUES;
          tok_d   = int'(in_thread) < THREADS;
          cnt_d   = '0;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (out_free) begin
          case (op_q)
            mqwl_pkg::OP_SLEEP: begin
              if (!qok_q || !tok_q) begin
                emit    = 1'b1;
                e_st    = mqwl_pkg::ST_NOTHING;
                state_d = S_IDLE;
              end else if (waiting_q[t_q]) begin
                emit    = 1'b1;
                e_st    = mqwl_pkg::ST_REFUSED;
                state_d = S_IDLE;
              end else if (sig_q) begin
                emit    = 1'b1;
                e_st    = mqwl_pkg::ST_INTERRUPTED;
                state_d = S_IDLE;
              end else if (nonempty_q[q_q]) begin
                state_d = S_SLP_LINK;
              end else begin
                // empty queue: thread becomes head and tail
                head_we         = 1'b1;
                tail_we         = 1'b1;
                wq_we           = 1'b1;
                nonempty_d[q_q] = 1'b1;
                waiting_d[t_q]  = 1'b1;
                emit            = 1'b1;
                state_d         = S_IDLE;
              end
            end
            mqwl_pkg::OP_WAKE_ONE, mqwl_pkg::OP_WAKE_ALL: begin
              if (!qok_q || !nonempty_q[q_q]) begin
                emit    = 1'b1;
                e_st    = mqwl_pkg::ST_NOTHING;
                state_d = S_IDLE;
              end else begin
                state_d = S_WK_HEAD;
              end
            end
            mqwl_pkg::OP_REMOVE: begin
              if (!tok_q || !waiting_q[t_q]) begin
                emit    = 1'b1;
                e_st    = mqwl_pkg::ST_NOTHING;
                state_d = S_IDLE;
              end else begin
                state_d = S_RM_QUEUE;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // append behind the current tail
      S_SLP_LINK: begin
        if (out_free) begin
          next_we        = 1'b1;
          next_waddr     = tail_rdata;
          next_wdata     = t_q;
          tail_we        = 1'b1;
          wq_we          = 1'b1;
          waiting_d[t_q] = 1'b1;
          emit           = 1'b1;
          state_d        = S_IDLE;
        end
      end

      S_WK_HEAD: begin
        cur_d   = head_rdata;
        tl_d    = tail_rdata;
        state_d = S_WK_WAIT;
      end

      S_WK_WAIT: begin
        state_d = S_WK_EMIT;
      end

      // pop one thread per pass
      S_WK_EMIT: begin
        if (out_free) begin
          waiting_d[cur_q] = 1'b0;
          emit             = 1'b1;
          e_thr            = mqwl_pkg::TID_W'(cur_q);
          e_wv             = 1'b1;
          if (hit) begin
            nonempty_d[q_q] = 1'b0;
            state_d         = S_IDLE;
          end else if (op_q == mqwl_pkg::OP_WAKE_ONE ||
                       cnt_q == CNTW'(mqwl_pkg::MAX_RESULTS - 1)) begin
            head_we    = 1'b1;
            head_wdata = next_rdata;
            state_d    = S_IDLE;
          end else begin
            e_last  = 1'b0;
            cur_d   = next_rdata;
            cnt_d   = cnt_q + 1'b1;
            state_d = S_WK_WAIT;
          end
        end
      end

      S_RM_QUEUE: begin
        q_d     = wq_rdata;
        state_d = S_RM_ADDR;
      end

      S_RM_ADDR: begin
        state_d = S_RM_HT;
      end

      S_RM_HT: begin
        cur_d    = head_rdata;
        tl_d     = tail_rdata;
        prev_v_d = 1'b0;
        state_d  = S_RM_WAIT;
      end

      S_RM_WAIT: begin
        state_d = S_RM_WALK;
      end

      // walk to the thread, then splice it out
      S_RM_WALK: begin
        if (hit) begin
          if (out_free) begin
            if (prev_v_q) begin
              next_we = 1'b1;
            end else begin
              head_we    = 1'b1;
              head_wdata = next_rdata;
            end
            if (t_is_tail) begin
              if (prev_v_q) begin
                tail_we    = 1'b1;
                tail_wdata = prev_q;
              end else begin
                nonempty_d[q_q] = 1'b0;
              end
            end
            waiting_d[t_q] = 1'b0;
            emit           = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          prev_d   = cur_q;
          prev_v_d = 1'b1;
          cur_d    = next_rdata;
          state_d  = S_RM_WAIT;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // output register
    out_v_d    = out_v_q && !m_axis_tready_i;
    out_thr_d  = out_thr_q;
    out_wv_d   = out_wv_q;
    out_st_d   = out_st_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_v_d    = 1'b1;
      out_thr_d  = e_thr;
      out_wv_d   = e_wv;
      out_st_d   = e_st;
      out_last_d = e_last;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= mqwl_pkg::OP_SLEEP;
      q_q        <= '0;
      t_q        <= '0;
      sig_q      <= 1'b0;
      qok_q      <= 1'b0;
      tok_q      <= 1'b0;
      cur_q      <= '0;
      prev_q     <= '0;
      prev_v_q   <= 1'b0;
      tl_q       <= '0;
      cnt_q      <= '0;
      nonempty_q <= '0;
      waiting_q  <= '0;
      out_v_q    <= 1'b0;
      out_thr_q  <= '0;
      out_wv_q   <= 1'b0;
      out_st_q   <= mqwl_pkg::ST_DONE;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      q_q        <= q_d;
      t_q        <= t_d;
      sig_q      <= sig_d;
      qok_q      <= qok_d;
      tok_q      <= tok_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      prev_v_q   <= prev_v_d;
      tl_q       <= tl_d;
      cnt_q      <= cnt_d;
      nonempty_q <= nonempty_d;
      waiting_q  <= waiting_d;
      out_v_q    <= out_v_d;
      out_thr_q  <= out_thr_d;
      out_wv_q   <= out_wv_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_st_q, out_wv_q, out_thr_q};
  assign m_axis_tlast_o  = out_last_q;

  // a woken thread always comes with status done
  a_woken_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[5]) |-> (m_axis_tdata_o[7:6] == mqwl_pkg::ST_DONE))
    else $error("woken word without status done");

  // a word that wakes nothing is the only word of its operation
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[5]) |-> m_axis_tlast_o)
    else $error("non-wake word without tlast");

  // one operation in flight
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while an operation runs");

  // every popped thread was marked waiting
  a_pop_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WK_EMIT) |-> waiting_q[cur_q])
    else $error("popped thread not marked waiting");

  // each nonempty queue holds at least one waiting thread
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(waiting_q) >= $countones(nonempty_q))
    else $error("more nonempty queues than waiting threads");

endmodule

>>> dv/multi_queue_wait_list_manager_tb.sv
`timescale 1ns / 1ps
// multi_queue_wait_list_manager_tb: self-checking bench for the wait list manager
// depends on mqwl_pkg and multi_queue_wait_list_manager; a shadow of the queues
// predicts every output word, random gaps and stalls on both streams

module multi_queue_wait_list_manager_tb;

  localparam int          NUM_THREADS = mqwl_pkg::THREADS_DEF;
  localparam int          NUM_QUEUES  = mqwl_pkg::QUEUES_DEF;
  localparam logic [5:0]  NIL         = 6'h3F;
  localparam int          RANDOM_OPS  = 350;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          DRAIN_WAIT  = 120;

  // one output word as the block should present it
  typedef struct packed {
    logic [4:0]        thr;
    logic              vld;
    mqwl_pkg::status_e st;
    logic              lst;
  } wake_word_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [mqwl_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [mqwl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                              m_axis_tlast;

  multi_queue_wait_list_manager dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow wait lists
  logic [5:0] q_head [NUM_QUEUES];
  logic [5:0] q_tail [NUM_QUEUES];
  logic [5:0] t_next [NUM_THREADS];
  logic [3:0] t_queue [NUM_THREADS];
  bit         t_waits [NUM_THREADS];

  logic [mqwl_pkg::IN_TDATA_W-1:0] pending_ops [$];
  wake_word_t                      wake_results [$];
  wake_word_t                      due;
  int                              errors = 0;
  int                              cycle_cnt = 0;
  int                              op_count = 0;
  int                              send_gap = 0;
  int                              stall_left = 0;
  bit                              op_taken = 1'b0;
  bit                              calm;

  // stretches of the run with no idling on either side
  assign calm = ((cycle_cnt / 1500) % 3) == 0;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [mqwl_pkg::IN_TDATA_W-1:0] op_word(mqwl_pkg::op_e op,
                                                              logic [3:0] q,
                                                              logic [4:0] t,
                                                              logic sig);
    return {4'b0, sig, t, q, op};
  endfunction

  task automatic push_result(logic [4:0] thr, logic vld, mqwl_pkg::status_e st,
                             logic lst);
    wake_word_t w;
    w.thr = thr;
    w.vld = vld;
    w.st  = st;
    w.lst = lst;
    wake_results.push_back(w);
  endtask

  // apply one operation to the shadow lists and queue the words it yields
  task automatic predict_wait_lists(logic [mqwl_pkg::IN_TDATA_W-1:0] w);
    mqwl_pkg::op_e op;
    logic [3:0]    q;
    logic [4:0]    t;
    logic          sig;
    logic [5:0]    cur;
    logic [5:0]    prev;
    logic [3:0]    wq;
    int            n;
    int            steps;
    op  = mqwl_pkg::op_e'(w[1:0]);
    q   = w[5:2];
    t   = w[10:6];
    sig = w[11];
    case (op)
      mqwl_pkg::OP_SLEEP: begin
        if (t_waits[t]) begin
          push_result('0, 1'b0, mqwl_pkg::ST_REFUSED, 1'b1);
        end else if (sig) begin
          push_result('0, 1'b0, mqwl_pkg::ST_INTERRUPTED, 1'b1);
        end else begin
          t_next[t] = NIL;
          if (q_tail[q] != NIL) t_next[q_tail[q][4:0]] = {1'b0, t};
          else q_head[q] = {1'b0, t};
          q_tail[q] = {1'b0, t};
          t_waits[t] = 1'b1;
          t_queue[t] = q;
          push_result('0, 1'b0, mqwl_pkg::ST_DONE, 1'b1);
        end
      end
      mqwl_pkg::OP_WAKE_ONE, mqwl_pkg::OP_WAKE_ALL: begin
        if (q_head[q] == NIL) begin
          push_result('0, 1'b0, mqwl_pkg::ST_NOTHING, 1'b1);
        end else begin
          n = 0;
          do begin
            cur = q_head[q];
            q_head[q] = t_next[cur[4:0]];
            if (q_head[q] == NIL) q_tail[q] = NIL;
            t_next[cur[4:0]] = NIL;
            t_waits[cur[4:0]] = 1'b0;
            push_result(cur[4:0], 1'b1, mqwl_pkg::ST_DONE,
                        op == mqwl_pkg::OP_WAKE_ONE || q_head[q] == NIL ||
                        n == mqwl_pkg::MAX_RESULTS - 1);
            n++;
          end while (op == mqwl_pkg::OP_WAKE_ALL && q_head[q] != NIL &&
                     n < mqwl_pkg::MAX_RESULTS);
        end
      end
      default: begin
        if (!t_waits[t]) begin
          push_result('0, 1'b0, mqwl_pkg::ST_NOTHING, 1'b1);
        end else begin
          // walk to the thread, then splice it out and fix the tail
          wq = t_queue[t];
          cur = q_head[wq];
          prev = NIL;
          steps = 0;
          while (cur != NIL && cur[4:0] != t && steps < NUM_THREADS) begin
            prev = cur;
            cur = t_next[cur[4:0]];
            steps++;
          end
          if (cur != NIL && cur[4:0] == t) begin
            if (prev != NIL) t_next[prev[4:0]] = t_next[t];
            else q_head[wq] = t_next[t];
            if (q_tail[wq] == {1'b0, t}) q_tail[wq] = prev;
          end
          t_next[t] = NIL;
          t_waits[t] = 1'b0;
          push_result('0, 1'b0, mqwl_pkg::ST_DONE, 1'b1);
        end
      end
    endcase
  endtask

  task automatic add_op(mqwl_pkg::op_e op, logic [3:0] q, logic [4:0] t, logic sig);
    pending_ops.push_back(op_word(op, q, t, sig));
    op_count++;
  endtask

  // empty every queue, park all threads on one queue, release them at once
  task automatic add_flood(logic [3:0] q);
    int perm [NUM_THREADS];
    int j;
    int tmp;
    for (int i = 0; i < NUM_QUEUES; i++)
      add_op(mqwl_pkg::OP_WAKE_ALL, i[3:0], 5'($urandom), 1'b0);
    for (int i = 0; i < NUM_THREADS; i++) perm[i] = i;
    for (int i = NUM_THREADS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < NUM_THREADS; i++)
      add_op(mqwl_pkg::OP_SLEEP, q, perm[i][4:0], 1'b0);
    add_op(mqwl_pkg::OP_WAKE_ALL, q, 5'($urandom), 1'b0);
  endtask

  function automatic logic [3:0] pick_queue();
    if ($urandom_range(0, 4) == 0) return 4'($urandom_range(0, NUM_QUEUES - 1));
    return 4'($urandom_range(0, 3));
  endfunction

  // input driver: holds each word until taken, then idles or sends the next
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (op_taken) void'(pending_ops.pop_front());
      if (s_axis_tvalid && !op_taken) begin
        // word still waiting for tready
      end else if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_ops.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_ops[0];
        send_gap <= draw_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 2) == 0 && draw_gap() > 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= draw_gap();
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor: check output words, then predict from taken input words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (wake_results.size() == 0) begin
          $error("output word with nothing expected: tdata=%h tlast=%b",
                 m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          due = wake_results.pop_front();
          if (m_axis_tdata[4:0] !== due.thr) begin
            $error("woken_thread: expected %0d, got %0d", due.thr, m_axis_tdata[4:0]);
            errors++;
          end
          if (m_axis_tdata[5] !== due.vld) begin
            $error("woken_valid: expected %0d, got %0d", due.vld, m_axis_tdata[5]);
            errors++;
          end
          if (m_axis_tdata[7:6] !== due.st) begin
            $error("status: expected %0d, got %0d", due.st, m_axis_tdata[7:6]);
            errors++;
          end
          if (m_axis_tlast !== due.lst) begin
            $error("last: expected %0d, got %0d", due.lst, m_axis_tlast);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_wait_lists(s_axis_tdata);
      op_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("multi_queue_wait_list_manager regression: fail");
      $finish;
    end
  end

  initial begin
    int r;
    int k;
    int floods;
    logic [3:0] q;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_head[i] = NIL;
      q_tail[i] = NIL;
    end
    for (int i = 0; i < NUM_THREADS; i++) begin
      t_next[i] = NIL;
      t_queue[i] = '0;
      t_waits[i] = 1'b0;
    end

    // directed: empty queues, idle remove, signal, refusal, unlink and wakes
    add_op(mqwl_pkg::OP_WAKE_ONE, 4'd0, 5'd31, 1'b1);
    add_op(mqwl_pkg::OP_WAKE_ALL, 4'd15, 5'd0, 1'b0);
    add_op(mqwl_pkg::OP_REMOVE, 4'd15, 5'd0, 1'b1);
    add_op(mqwl_pkg::OP_SLEEP, 4'd0, 5'd0, 1'b1);
    add_op(mqwl_pkg::OP_SLEEP, 4'd0, 5'd0, 1'b0);
    add_op(mqwl_pkg::OP_SLEEP, 4'd15, 5'd0, 1'b1);
    add_op(mqwl_pkg::OP_SLEEP, 4'd15, 5'd0, 1'b0);
    add_op(mqwl_pkg::OP_SLEEP, 4'd15, 5'd31, 1'b0);
    add_op(mqwl_pkg::OP_SLEEP, 4'd15, 5'd1, 1'b0);
    add_op(mqwl_pkg::OP_SLEEP, 4'd15, 5'd2, 1'b0);
    add_op(mqwl_pkg::OP_REMOVE, 4'd0, 5'd1, 1'b0);
    add_op(mqwl_pkg::OP_REMOVE, 4'd0, 5'd2, 1'b0);
    add_op(mqwl_pkg::OP_SLEEP, 4'd15, 5'd3, 1'b0);
    add_op(mqwl_pkg::OP_SLEEP, 4'd15, 5'd4, 1'b0);
    add_op(mqwl_pkg::OP_REMOVE, 4'd0, 5'd31, 1'b0);
    add_op(mqwl_pkg::OP_REMOVE, 4'd0, 5'd31, 1'b0);
    add_op(mqwl_pkg::OP_WAKE_ONE, 4'd15, 5'd0, 1'b0);
    add_op(mqwl_pkg::OP_WAKE_ALL, 4'd15, 5'd31, 1'b1);
    add_op(mqwl_pkg::OP_WAKE_ONE, 4'd0, 5'd0, 1'b0);
    add_op(mqwl_pkg::OP_WAKE_ONE, 4'd0, 5'd0, 1'b0);
    add_op(mqwl_pkg::OP_SLEEP, 4'd0, 5'd0, 1'b0);

    // random mix of list-building sequences, wakes, removes and noise
    op_count = 0;
    floods = 0;
    while (op_count < RANDOM_OPS) begin
      r = $urandom_range(0, 99);
      q = pick_queue();
      if (r < 35) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          add_op(mqwl_pkg::OP_SLEEP, q, 5'($urandom), $urandom_range(0, 9) == 0);
      end else if (r < 55) begin
        add_op(mqwl_pkg::OP_WAKE_ONE, q, 5'($urandom), 1'($urandom));
      end else if (r < 65) begin
        add_op(mqwl_pkg::OP_WAKE_ALL, q, 5'($urandom), 1'($urandom));
      end else if (r < 85) begin
        add_op(mqwl_pkg::OP_REMOVE, 4'($urandom), 5'($urandom), 1'($urandom));
      end else if (r < 97 || floods >= 2) begin
        add_op(mqwl_pkg::op_e'($urandom_range(0, 3)), 4'($urandom), 5'($urandom),
               1'($urandom));
      end else begin
        add_flood(4'($urandom));
        floods++;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || wake_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (errors == 0) begin
      $display("multi_queue_wait_list_manager regression: pass");
    end else begin
      $display("multi_queue_wait_list_manager regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/mqwl_pkg.sv
src/mqwl_ram.sv
src/multi_queue_wait_list_manager.sv
dv/multi_queue_wait_list_manager_tb.sv
